FILE: hw/rtl/stfg_pkg.sv
`default_nettype none

package stfg_pkg;

  localparam int unsigned MaxFrameLen = 1000;
  localparam int unsigned PayloadLen  = 250;

  localparam int unsigned PosW   = 10;  // byte position and frame length
  localparam int unsigned PreW   = 8;
  localparam int unsigned SyncW  = 32;
  localparam int unsigned LenW   = 8;
  localparam int unsigned ScrW   = 17;
  localparam int unsigned IdxW   = 3;
  localparam int unsigned DataW  = 32;
  localparam int unsigned PartW  = 3;

  localparam logic [7:0] PreambleByte = 8'h55;

  // register indexes
  localparam logic [IdxW-1:0] RegPreambleLen = 3'd0;
  localparam logic [IdxW-1:0] RegSyncPattern = 3'd1;
  localparam logic [IdxW-1:0] RegLengthField = 3'd2;
  localparam logic [IdxW-1:0] RegFrameLen    = 3'd3;

  // reset values
  localparam logic [PreW-1:0]  PreambleLenRst = 8'd50;
  localparam logic [SyncW-1:0] SyncPatternRst = 32'hDE51_0B93;
  localparam logic [LenW-1:0]  LengthFieldRst = 8'd200;
  localparam logic [PosW-1:0]  FrameLenRst    = PosW'(MaxFrameLen);

  // frame part codes
  localparam logic [PartW-1:0] PartPreamble = 3'd0;
  localparam logic [PartW-1:0] PartSync     = 3'd1;
  localparam logic [PartW-1:0] PartLength   = 3'd2;
  localparam logic [PartW-1:0] PartPayload  = 3'd3;
  localparam logic [PartW-1:0] PartPadding  = 3'd4;

  typedef struct packed {
    logic [PreW-1:0]  pre_count;
    logic [SyncW-1:0] sync_pattern;
    logic [LenW-1:0]  length_field;
    logic [PosW-1:0]  frame_len;
  } cfg_t;

  typedef struct packed {
    logic [ScrW-1:0] state;
    logic [7:0]      data;
  } scr_res_t;

  // eight scrambler steps, MSB first; bit 4 takes the feedback before the shift
  function automatic scr_res_t scramble_byte(input logic [ScrW-1:0] state_in,
                                             input logic [7:0] data_in);
    logic [ScrW-1:0] s;
    logic [7:0]      r;
    logic            t;
    s = state_in;
    r = '0;
    for (int j = 7; j >= 0; j--) begin
      t    = s[ScrW-1];
      s[4] = s[4] ^ t;
      s    = {s[ScrW-2:0], data_in[j] ^ t};
      r[j] = t;
    end
    return '{state: s, data: r};
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/scrambled_test_frame_generator.sv
// Scrambled test frame generator.
// Each transfer on the tick channel (in_valid_i, in_stall_o, restart_i) yields
// one frame byte on the output channel (out_valid_o, out_stall_i, tx_byte_o,
// frame_part_o, last_of_frame_o). restart_i = 1 drops the current frame and
// the result is byte zero of a new one.
// Frame: preamble of 0x55, sync word LSB first, length byte, 250 counting
// payload bytes, zero padding; scrambled from the sync word on.
// Configuration goes through cfg_valid_i / cfg_index_i / cfg_data_i; ready is
// always high. Write only while the block is idle.
// Pipeline: a tick register, then the combinational byte select and
// eight-step scrambler network, then the result register. A taken tick is
// held in the tick register, then loaded into the result register; one item
// per cycle sustained while out_stall_i stays low.
// While out_stall_i holds, the result register keeps its byte; one more tick
// is held in the tick register, then in_stall_o rises.
// Reset clears the position, scrambler and both pipeline valid flags and
// loads the configuration defaults.
`default_nettype none

module scrambled_test_frame_generator
  import stfg_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic             restart_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [7:0]            tx_byte_o,
  output logic [PartW-1:0]      frame_part_o,
  output logic                  last_of_frame_o,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [IdxW-1:0]  cfg_index_i,
  input  wire logic [DataW-1:0] cfg_data_i
);

  cfg_t             cfg;
  logic             tick_valid_q, tick_valid_d;
  logic             restart_q;
  logic             out_valid_q, out_valid_d;
  logic [7:0]       tx_byte_q;
  logic [PartW-1:0] frame_part_q;
  logic             last_q;
  logic             out_free, advance, in_take;
  logic [7:0]       core_byte;
  logic [PartW-1:0] core_part;
  logic             core_last;

  assign cfg_ready_o = 1'b1;

  stfg_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = tick_valid_q && out_free;
  assign in_stall_o = tick_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  stfg_frame_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .step_i       (advance),
    .restart_i    (restart_q),
    .tx_byte_o    (core_byte),
    .frame_part_o (core_part),
    .last_o       (core_last)
  );

  always_comb begin
    tick_valid_d = tick_valid_q;
    if (in_take) begin
      tick_valid_d = 1'b1;
    end else if (advance) begin
      tick_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      tick_valid_q <= tick_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      restart_q <= restart_i;
    end
    if (advance) begin
      tx_byte_q    <= core_byte;
      frame_part_q <= core_part;
      last_q       <= core_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign tx_byte_o       = tx_byte_q;
  assign frame_part_o    = frame_part_q;
  assign last_of_frame_o = last_q;

endmodule

`default_nettype wire

FILE: hw/rtl/stfg_cfg_regs.sv
`default_nettype none

module stfg_cfg_regs
  import stfg_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             wr_en_i,
  input  wire logic [IdxW-1:0]  wr_index_i,
  input  wire logic [DataW-1:0] wr_data_i,
  output cfg_t                  cfg_o
);

  cfg_t            cfg_q, cfg_d;
  logic [PosW-1:0] flen_raw;
  logic [PosW-1:0] flen_sat;

  always_comb begin
    flen_raw = wr_data_i[PosW-1:0];
    if (flen_raw > PosW'(MaxFrameLen)) begin
      flen_sat = PosW'(MaxFrameLen);
    end else if (flen_raw == '0) begin
      flen_sat = PosW'(1);
    end else begin
      flen_sat = flen_raw;
    end
  end

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_index_i)
        RegPreambleLen: cfg_d.pre_count    = wr_data_i[PreW-1:0];
        RegSyncPattern: cfg_d.sync_pattern = wr_data_i[SyncW-1:0];
        RegLengthField: cfg_d.length_field = wr_data_i[LenW-1:0];
        RegFrameLen:    cfg_d.frame_len    = flen_sat;
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{pre_count: PreambleLenRst, sync_pattern: SyncPatternRst,
                 length_field: LengthFieldRst, frame_len: FrameLenRst};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: hw/rtl/stfg_frame_core.sv
`default_nettype none

module stfg_frame_core
  import stfg_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cfg_t              cfg_i,
  input  wire logic              step_i,
  input  wire logic              restart_i,
  output logic [7:0]             tx_byte_o,
  output logic [PartW-1:0]       frame_part_o,
  output logic                   last_o
);

  logic [PosW-1:0] pos_q, pos_d, pos_cur;
  logic [ScrW-1:0] scr_q, scr_d, scr_cur;
  logic [PosW:0]   offset;
  logic [7:0]      raw;
  logic            in_preamble;
  scr_res_t        scr_res;

  assign pos_cur = restart_i ? '0 : pos_q;
  assign scr_cur = restart_i ? '0 : scr_q;

  assign in_preamble = {1'b0, pos_cur} < (PosW+1)'(cfg_i.pre_count);
  assign offset      = {1'b0, pos_cur} - (PosW+1)'(cfg_i.pre_count);

  always_comb begin
    if (in_preamble) begin
      raw          = PreambleByte;
      frame_part_o = PartPreamble;
    end else if (offset < (PosW+1)'(4)) begin
      raw          = cfg_i.sync_pattern[{offset[1:0], 3'b000} +: 8];
      frame_part_o = PartSync;
    end else if (offset == (PosW+1)'(4)) begin
      raw          = cfg_i.length_field;
      frame_part_o = PartLength;
    end else if (offset < (PosW+1)'(5 + PayloadLen)) begin
      raw          = 8'(offset - (PosW+1)'(5));
      frame_part_o = PartPayload;
    end else begin
      raw          = '0;
      frame_part_o = PartPadding;
    end
  end

  assign scr_res   = scramble_byte(scr_cur, raw);
  assign tx_byte_o = in_preamble ? raw : scr_res.data;
  assign last_o    = ({1'b0, pos_cur} + (PosW+1)'(1)) >= {1'b0, cfg_i.frame_len};

  always_comb begin
    pos_d = pos_q;
    scr_d = scr_q;
    if (step_i) begin
      if (last_o) begin
        pos_d = '0;
        scr_d = '0;
      end else begin
        pos_d = pos_cur + PosW'(1);
        scr_d = in_preamble ? scr_cur : scr_res.state;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      scr_q <= '0;
    end else begin
      pos_q <= pos_d;
      scr_q <= scr_d;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/stfg_checker.sv
`default_nettype none

module stfg_checker
  import stfg_pkg::*;
(
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_stall_o,
  input wire logic             out_valid_o,
  input wire logic             out_stall_i,
  input wire logic [7:0]       tx_byte_o,
  input wire logic [PartW-1:0] frame_part_o
);

  // the tick side only stalls behind a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("tick stalled without a stalled result");

  a_part_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (frame_part_o == PartPreamble || frame_part_o == PartSync ||
                     frame_part_o == PartLength || frame_part_o == PartPayload ||
                     frame_part_o == PartPadding))
    else $error("frame part code out of range");

  // a fresh result always traces back to a tick transfer
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result without tick");

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("result dropped while stalled");

  a_byte_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(tx_byte_o))
    else $error("stalled byte changed");

endmodule

bind scrambled_test_frame_generator stfg_checker u_stfg_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .tx_byte_o    (tx_byte_o),
  .frame_part_o (frame_part_o)
);

`default_nettype wire

FILE: dv/scrambled_test_frame_generator_tb.sv
`timescale 1ns / 100ps

module scrambled_test_frame_generator_tb
  import stfg_pkg::*;
();

  typedef struct packed {
    logic [7:0]       tx_byte;
    logic [PartW-1:0] part;
    logic             last;
  } frame_byte_t;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_stall_o;
  logic             restart_i   = 1'b0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [7:0]       tx_byte_o;
  logic [PartW-1:0] frame_part_o;
  logic             last_of_frame_o;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [IdxW-1:0]  cfg_index_i = '0;
  logic [DataW-1:0] cfg_data_i  = '0;

  scrambled_test_frame_generator dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .restart_i,
    .out_valid_o,
    .out_stall_i,
    .tx_byte_o,
    .frame_part_o,
    .last_of_frame_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  // predictor copy of the configuration and frame state
  logic [PreW-1:0]  pre_len   = PreambleLenRst;
  logic [SyncW-1:0] sync_val  = SyncPatternRst;
  logic [LenW-1:0]  len_byte  = LengthFieldRst;
  logic [PosW-1:0]  frm_len   = FrameLenRst;
  logic [PosW-1:0]  frm_pos   = '0;
  logic [ScrW-1:0]  scr_q     = '0;

  frame_byte_t pending_bytes[$];

  int sender_idle_pct = 0;
  int stall_pct       = 0;
  int errors          = 0;
  int ticks_sent      = 0;
  int restarts_sent   = 0;
  int frames_done     = 0;
  int cfg_writes      = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // 17-bit whitener, MSB first; the fed-back bit lands in bit 5 after the shift
  function automatic logic [7:0] whiten(input logic [7:0] din);
    logic [7:0] dout;
    logic       fb;
    for (int k = 7; k >= 0; k--) begin
      fb      = scr_q[ScrW-1];
      dout[k] = fb;
      scr_q   = {scr_q[15:5], scr_q[4] ^ fb, scr_q[3:0], din[k] ^ fb};
    end
    return dout;
  endfunction

  function automatic frame_byte_t next_frame_byte(input logic rs);
    frame_byte_t b;
    int          pos;
    int          pre;
    logic [7:0]  raw;
    if (rs) begin
      frm_pos = '0;
      scr_q   = '0;
    end
    pos = int'(frm_pos);
    pre = int'(pre_len);
    if (pos < pre) begin
      raw    = PreambleByte;
      b.part = PartPreamble;
    end else if (pos < pre + 4) begin
      raw    = sync_val[8*(pos-pre) +: 8];
      b.part = PartSync;
    end else if (pos == pre + 4) begin
      raw    = len_byte;
      b.part = PartLength;
    end else if (pos < pre + 5 + int'(PayloadLen)) begin
      raw    = 8'(pos - pre - 5);
      b.part = PartPayload;
    end else begin
      raw    = 8'h00;
      b.part = PartPadding;
    end
    b.tx_byte = (pos < pre) ? raw : whiten(raw);
    b.last    = (pos + 1 >= int'(frm_len));
    if (b.last) begin
      frm_pos = '0;
      scr_q   = '0;
    end else begin
      frm_pos = frm_pos + 1'b1;
    end
    return b;
  endfunction

  // outputs are stable from the falling edge up to the edge that takes the transfer
  always @(negedge clk_i) begin
    frame_byte_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_bytes.size() == 0) begin
        $error("unexpected byte: tx_byte %02h part %0d last %0b",
               tx_byte_o, frame_part_o, last_of_frame_o);
        errors++;
      end else begin
        want = pending_bytes.pop_front();
        if (tx_byte_o !== want.tx_byte) begin
          $error("tx_byte: expected %02h, got %02h", want.tx_byte, tx_byte_o);
          errors++;
        end
        if (frame_part_o !== want.part) begin
          $error("frame_part: expected %0d, got %0d", want.part, frame_part_o);
          errors++;
        end
        if (last_of_frame_o !== want.last) begin
          $error("last_of_frame: expected %0b, got %0b", want.last, last_of_frame_o);
          errors++;
        end
        if (want.last) frames_done++;
      end
    end
  end

  task automatic send_tick(input logic rs);
    bit took;
    in_valid_i  <= 1'b1;
    restart_i   <= rs;
    cfg_valid_i <= 1'b0;
    do begin
      @(negedge clk_i);
      took = !in_stall_o;
      @(posedge clk_i);
    end while (!took);
    pending_bytes.push_back(next_frame_byte(rs));
    ticks_sent++;
    if (rs) restarts_sent++;
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      restart_i  <= 1'($urandom);
      do @(posedge clk_i); while ($urandom_range(99) < sender_idle_pct);
    end
  endtask

  // leaves cfg_valid_i high; the next tick or drain lowers it
  task automatic write_reg(input logic [IdxW-1:0] idx, input logic [DataW-1:0] val);
    bit              took;
    logic [PosW-1:0] fl;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do begin
      @(negedge clk_i);
      took = cfg_ready_o;
      @(posedge clk_i);
    end while (!took);
    case (idx)
      RegPreambleLen: pre_len = val[PreW-1:0];
      RegSyncPattern: sync_val = val;
      RegLengthField: len_byte = val[LenW-1:0];
      RegFrameLen: begin
        fl = val[PosW-1:0];
        if (fl > MaxFrameLen) fl = PosW'(MaxFrameLen);
        if (fl == 0) fl = PosW'(1);
        frm_len = fl;
      end
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic drain();
    in_valid_i  <= 1'b0;
    cfg_valid_i <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic random_setup();
    int pick;
    int val;
    pick = $urandom_range(99);
    if (pick < 60) val = $urandom_range(8);
    else if (pick < 90) val = $urandom_range(9, 60);
    else val = $urandom_range(255);
    write_reg(RegPreambleLen, DataW'(val));
    write_reg(RegSyncPattern, $urandom);
    write_reg(RegLengthField, DataW'($urandom_range(255)));
    pick = $urandom_range(99);
    if (pick < 55) write_reg(RegFrameLen, DataW'($urandom_range(1, 40)));
    else if (pick < 80) write_reg(RegFrameLen, DataW'($urandom_range(41, 120)));
    else if (pick < 95) write_reg(RegFrameLen, DataW'($urandom_range(255, 330)));
    else write_reg(RegFrameLen, $urandom);
  endtask

  task automatic test_defaults();
    sender_idle_pct = 0;
    stall_pct       = 0;
    repeat (3) send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
  endtask

  task automatic test_zero_preamble();
    drain();
    write_reg(RegPreambleLen, '0);
    write_reg(RegSyncPattern, '1);
    write_reg(RegLengthField, DataW'(255));
    write_reg(RegFrameLen, DataW'(9));
    send_tick(1'b1);
    repeat (9) send_tick(1'b0);
  endtask

  // zero after masking becomes one; oversize saturates; unused indexes do nothing
  task automatic test_tiny_frames();
    drain();
    write_reg(RegFrameLen, 32'hFFFF_FC00);
    send_tick(1'b0);
    send_tick(1'b1);
    drain();
    write_reg(RegFrameLen, 32'h0000_03FF);
    for (int k = 1; k <= 4; k++) write_reg(IdxW'(RegFrameLen + k), $urandom);
  endtask

  task automatic test_shrink();
    drain();
    write_reg(RegPreambleLen, DataW'(2));
    write_reg(RegSyncPattern, '0);
    write_reg(RegLengthField, '0);
    write_reg(RegFrameLen, DataW'(20));
    send_tick(1'b1);
    repeat (7) send_tick(1'b0);
    drain();
    // position is now past the new end, so the next byte closes the frame
    write_reg(RegFrameLen, DataW'(4));
    repeat (2) send_tick(1'b0);
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct_v, input int budget);
    int sent;
    int n;
    int rs_pct;
    sender_idle_pct = idle_pct;
    stall_pct       = stall_pct_v;
    sent            = 0;
    while (sent < budget) begin
      drain();
      random_setup();
      rs_pct = ($urandom_range(1) == 0) ? 0 : 4;
      n = int'(frm_len) + $urandom_range(20);
      if (n > 60) n = 60;
      repeat (n) send_tick($urandom_range(99) < rs_pct);
      sent += n;
    end
  endtask

  // whole payload and a few padding bytes in one frame
  task automatic test_long_frame();
    drain();
    sender_idle_pct = 29;
    stall_pct       = 29;
    write_reg(RegPreambleLen, DataW'(2));
    write_reg(RegFrameLen, DataW'(262));
    send_tick(1'b1);
    repeat (261) send_tick(1'b0);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_defaults();
    test_zero_preamble();
    test_tiny_frames();
    test_shrink();
    run_phase(0, 0, 40);
    run_phase(70, 0, 40);
    run_phase(0, 70, 40);
    run_phase(29, 29, 40);
    test_long_frame();
    drain();
    repeat (10) @(posedge clk_i);
    $display("Sent %0d ticks (%0d restarts), saw %0d frame ends, %0d register writes.",
             ticks_sent, restarts_sent, frames_done, cfg_writes);
    $display("Frames ran over short, zero-preamble, shrunk and long padded settings.");
    if (errors == 0 && pending_bytes.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
